### rtl/gds_pkg.sv
// ----------------------------------------------------------------------------
// gds_pkg - shared types and calendar helpers
// Date record, command codes, register indexes and the Gregorian month and
// leap-year rules used by the step logic and the weekday stage.
// ----------------------------------------------------------------------------
`default_nettype none

package gds_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    // command codes carried on the input tuser
    localparam logic [2:0] FUNC_LOAD       = 3'd0;
    localparam logic [2:0] FUNC_WEEK_BACK  = 3'd1;
    localparam logic [2:0] FUNC_WEEK_FWD   = 3'd2;
    localparam logic [2:0] FUNC_DAY_BACK   = 3'd3;
    localparam logic [2:0] FUNC_DAY_FWD    = 3'd4;
    localparam logic [2:0] FUNC_MONTH_BACK = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_MIN_YEAR = 2'd0;
    localparam logic [1:0] REG_MAX_YEAR = 2'd1;

    localparam logic [YEAR_W-1:0]  MIN_YEAR_RST = 14'd1900;
    localparam logic [YEAR_W-1:0]  MAX_YEAR_RST = 14'd9999;
    localparam logic [MONTH_W-1:0] JANUARY      = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY     = 4'd2;
    localparam logic [MONTH_W-1:0] MARCH        = 4'd3;
    localparam logic [MONTH_W-1:0] DECEMBER     = 4'd12;
    localparam logic [DAY_W-1:0]   LAST_DEC_DAY = 5'd31;

    // Divisibility by 25 of a 12-bit value: multiply by the inverse of 25
    // modulo 4096; multiples of 25 map onto 0..163 and nothing else does.
    function automatic logic div_by_25(input logic [11:0] x);
        logic [23:0] p;
        p = 24'(x) * 24'd3113;
        return p[11:0] <= 12'd163;
    endfunction

    // Leap when divisible by 4 and not by 100, or divisible by 400.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic by25;
        by25 = div_by_25(y[13:2]);
        return (y[1:0] == 2'd0) && (!by25 || (y[3:2] == 2'd0));
    endfunction

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] n;
        unique case (m)
            FEBRUARY:                     n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:      n = 5'd30;
            default:                      n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

### rtl/gregorian_date_stepper.sv
// ----------------------------------------------------------------------------
// gregorian_date_stepper - Gregorian calendar date stepper
// Holds one date and answers every command with the new date, the length of
// its month and the weekday of the first of the month.
// ----------------------------------------------------------------------------
// Usage:
//   Send one command per request on the s_ stream: tuser carries the command
//   (load, week back/forward, day back/forward, month back), tdata the date
//   to load. Every accepted request yields exactly one result request on
//   the m_ stream, in order.
//   The cfg channel writes min_year (index 0) and max_year (index 1); it is
//   always ready. Write it only while the block is idle.
// Timing:
//   Four register stages: input, held date, weekday sum, result. One request
//   is taken every cycle unless m_tready low has filled every stage. The held
//   date is updated directly from the previous one, which is what sets the
//   one-per-cycle rate.
// Reset:
//   The date returns to 1 January 1900, the year range to 1900..9999, and
//   every stage empties.
// Stall:
//   With m_tready low the stages fill up one by one; s_tready drops only
//   once all four hold a request, and nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_date_stepper
    import gds_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // command stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // load_year[15:0], load_month[19:16],
                                        // load_day[24:20], zero[31:25]
    input  wire logic [2:0]  s_tuser,   // func[2:0]

    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // year[13:0], month[17:14], day[22:18],
                                        // days_in_month[27:23],
                                        // first_weekday[30:28], zero[31]

    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [13:0] cfg_data
);

    // mod 7 by folding octal digits (8 = 1 mod 7)
    function automatic logic [2:0] mod7(input logic [14:0] s);
        logic [5:0] f0;
        logic [3:0] f1;
        logic [2:0] f2;
        f0 = 6'(s[2:0]) + 6'(s[5:3]) + 6'(s[8:6]) + 6'(s[11:9]) + 6'(s[14:12]);
        f1 = 4'(f0[2:0]) + 4'(f0[5:3]);
        f2 = f1[2:0] + 3'(f1[3]);
        return (f2 == 3'd7) ? 3'd0 : f2;
    endfunction

    // configuration
    logic [YEAR_W-1:0] min_year_reg;
    logic [YEAR_W-1:0] max_year_reg;
    logic [YEAR_W-1:0] upper_year;

    // stage A: input register
    logic              a_valid_reg;
    logic [2:0]        a_func_reg;
    logic [15:0]       a_year_reg;
    logic [3:0]        a_month_reg;
    logic [4:0]        a_day_reg;

    // stage B: the held date itself
    logic              b_valid_reg;
    date_t             cur_reg;
    date_t             cur_next;

    // stage C: weekday sum
    logic              c_valid_reg;
    date_t             c_date_reg;
    logic [14:0]       c_sum_reg;
    logic [DAY_W-1:0]  c_dim_reg;
    logic [14:0]       wday_sum;
    logic [DAY_W-1:0]  dim;

    // stage D: result register
    logic              out_valid_reg;
    date_t             out_date_reg;
    logic [DAY_W-1:0]  out_dim_reg;
    logic [2:0]        out_wday_reg;

    logic              a_ready;
    logic              b_ready;
    logic              c_ready;
    logic              d_ready;

    // each stage moves on when the one after it is empty or moving
    assign d_ready = !out_valid_reg || m_tready;
    assign c_ready = !c_valid_reg || d_ready;
    assign b_ready = !b_valid_reg || c_ready;
    assign a_ready = !a_valid_reg || b_ready;

    assign s_tready  = a_ready;
    assign cfg_ready = 1'b1;

    // an inverted range pins the year to min_year
    assign upper_year = (max_year_reg < min_year_reg) ? min_year_reg : max_year_reg;

    gds_step u_step (
        .func       (a_func_reg),
        .load_year  (a_year_reg),
        .load_month (a_month_reg),
        .load_day   (a_day_reg),
        .cur        (cur_reg),
        .lo         (min_year_reg),
        .hi         (upper_year),
        .nxt        (cur_next)
    );

    gds_weekday u_weekday (
        .date     (cur_reg),
        .wday_sum (wday_sum),
        .dim      (dim)
    );

    // control state: valid bits, configuration and the held date
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_year_reg  <= MIN_YEAR_RST;
            max_year_reg  <= MAX_YEAR_RST;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_reg.year  <= MIN_YEAR_RST;
            cur_reg.month <= JANUARY;
            cur_reg.day   <= 5'd1;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MIN_YEAR)
                    min_year_reg <= cfg_data;
                else if (cfg_index == REG_MAX_YEAR)
                    max_year_reg <= cfg_data;
            end
            if (a_ready)
                a_valid_reg <= s_tvalid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
            if (d_ready)
                out_valid_reg <= c_valid_reg;
            // advance the held date as a command enters stage B
            if (a_valid_reg && b_ready)
                cur_reg <= cur_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && a_ready)
        begin
            a_func_reg  <= s_tuser;
            a_year_reg  <= s_tdata[15:0];
            a_month_reg <= s_tdata[19:16];
            a_day_reg   <= s_tdata[24:20];
        end
        if (b_valid_reg && c_ready)
        begin
            c_date_reg <= cur_reg;
            c_sum_reg  <= wday_sum;
            c_dim_reg  <= dim;
        end
        if (c_valid_reg && d_ready)
        begin
            out_date_reg <= c_date_reg;
            out_dim_reg  <= c_dim_reg;
            out_wday_reg <= mod7(c_sum_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_wday_reg, out_dim_reg, out_date_reg.day,
                       out_date_reg.month, out_date_reg.year};

    // a result never names a day past the end of its month
    a_day_in_month: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_date_reg.day != 5'd0) && (out_date_reg.day <= out_dim_reg))
        else $error("result day outside its month");

    // the month field stays a calendar month
    a_month_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_date_reg.month >= JANUARY) && (out_date_reg.month <= DECEMBER))
        else $error("result month out of range");

    // back-pressure reaches the input only once every stage is full
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (a_valid_reg && b_valid_reg && c_valid_reg && out_valid_reg))
        else $error("input stalled with an empty stage");

    // stage C takes exactly the date held when it moved
    a_c_copy: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && c_ready) |=> (c_date_reg == $past(cur_reg)))
        else $error("weekday stage lost the held date");

endmodule

`default_nettype wire

### rtl/gds_step.sv
// ----------------------------------------------------------------------------
// gds_step - next-date logic
// Apply one command to the held date: clamped load, week or day steps,
// month back, then saturation to the allowed year range.
// ----------------------------------------------------------------------------
`default_nettype none

module gds_step
    import gds_pkg::*;
(
    input  wire logic [2:0]        func,
    input  wire logic [15:0]       load_year,
    input  wire logic [3:0]        load_month,
    input  wire logic [4:0]        load_day,
    input  wire date_t             cur,
    input  wire logic [YEAR_W-1:0] lo,
    input  wire logic [YEAR_W-1:0] hi,
    output date_t                  nxt
);

    logic             leap_cur;
    logic [DAY_W-1:0] n_cur;
    logic [DAY_W-1:0] n_prev;
    logic [3:0]       prev_m;
    logic [3:0]       next_m;
    logic [5:0]       d_plus7;

    // load path
    logic [15:0]       ly_hi;
    logic [15:0]       ly_clamp;
    logic [YEAR_W-1:0] ly;
    logic [3:0]        lm;
    logic [DAY_W-1:0]  n_load;
    logic [DAY_W-1:0]  ld1;
    date_t             load_date;

    // step path
    logic              inc_y;
    logic              dec_y;
    logic [3:0]        m_s;
    logic [DAY_W-1:0]  d_s;
    logic [YEAR_W:0]   y_s;
    logic              below;
    logic              above;
    date_t             step_date;

    always_comb
    begin
        leap_cur = is_leap(cur.year);
        n_cur    = month_length(cur.month, leap_cur);
        prev_m   = (cur.month == JANUARY) ? DECEMBER : cur.month - 4'd1;
        next_m   = (cur.month == DECEMBER) ? JANUARY : cur.month + 4'd1;
        // February is the previous month only from March, in the same year
        n_prev   = month_length(prev_m, leap_cur);
        d_plus7  = {1'b0, cur.day} + 6'd7;
    end

    // clamp the loaded date
    always_comb
    begin
        ly_hi    = (load_year > {2'b00, hi}) ? {2'b00, hi} : load_year;
        ly_clamp = (ly_hi < {2'b00, lo}) ? {2'b00, lo} : ly_hi;
        ly       = ly_clamp[YEAR_W-1:0];
        if (load_month > DECEMBER)
            lm = DECEMBER;
        else if (load_month == 4'd0)
            lm = JANUARY;
        else
            lm = load_month;
        n_load = month_length(lm, is_leap(ly));
        ld1    = (load_day == 5'd0) ? 5'd1 : load_day;
        load_date.year  = ly;
        load_date.month = lm;
        load_date.day   = (ld1 > n_load) ? n_load : ld1;
    end

    // step the held date
    always_comb
    begin
        inc_y = 1'b0;
        dec_y = 1'b0;
        m_s   = cur.month;
        d_s   = cur.day;
        unique case (func)
            FUNC_WEEK_BACK:
            begin
                if (cur.day > 5'd7)
                    d_s = cur.day - 5'd7;
                else
                begin
                    dec_y = (cur.month == JANUARY);
                    m_s   = prev_m;
                    d_s   = n_prev + cur.day - 5'd7;
                end
            end
            FUNC_WEEK_FWD:
            begin
                if (d_plus7 <= {1'b0, n_cur})
                    d_s = d_plus7[DAY_W-1:0];
                else
                begin
                    inc_y = (cur.month == DECEMBER);
                    m_s   = next_m;
                    d_s   = DAY_W'(d_plus7 - {1'b0, n_cur});
                end
            end
            FUNC_DAY_BACK:
            begin
                if (cur.day > 5'd1)
                    d_s = cur.day - 5'd1;
                else
                begin
                    dec_y = (cur.month == JANUARY);
                    m_s   = prev_m;
                    d_s   = n_prev;
                end
            end
            FUNC_DAY_FWD:
            begin
                if (cur.day < n_cur)
                    d_s = cur.day + 5'd1;
                else
                begin
                    inc_y = (cur.month == DECEMBER);
                    m_s   = next_m;
                    d_s   = 5'd1;
                end
            end
            FUNC_MONTH_BACK:
            begin
                dec_y = (cur.month == JANUARY);
                m_s   = prev_m;
                d_s   = (cur.day > n_prev) ? n_prev : cur.day;
            end
            default:
            begin
                // load handled apart; unused codes hold the date, subject to saturation
            end
        endcase

        y_s   = {1'b0, cur.year} + (YEAR_W+1)'(inc_y) - (YEAR_W+1)'(dec_y);
        // stepping back from year zero falls below any range
        below = (dec_y && (cur.year == '0)) || (y_s < {1'b0, lo});
        above = !below && (y_s > {1'b0, hi});

        if (below)
        begin
            step_date.year  = lo;
            step_date.month = JANUARY;
            step_date.day   = 5'd1;
        end
        else if (above)
        begin
            step_date.year  = hi;
            step_date.month = DECEMBER;
            step_date.day   = LAST_DEC_DAY;
        end
        else
        begin
            step_date.year  = y_s[YEAR_W-1:0];
            step_date.month = m_s;
            step_date.day   = d_s;
        end
    end

    assign nxt = (func == FUNC_LOAD) ? load_date : step_date;

endmodule

`default_nettype wire

### rtl/gds_weekday.sv
// ----------------------------------------------------------------------------
// gds_weekday - month length and weekday sum
// Form the days in the month and the un-reduced weekday sum of the first
// of the month; the mod-7 reduction follows in the next stage.
// ----------------------------------------------------------------------------
`default_nettype none

module gds_weekday
    import gds_pkg::*;
(
    input  wire date_t      date,
    output logic [14:0]     wday_sum,
    output logic [DAY_W-1:0] dim
);

    // floor(x / 25) by reciprocal; exact for x below 6400, where the quotient fits 8 bits
    function automatic logic [7:0] quot_25(input logic [12:0] x);
        logic [25:0] p;
        p = 26'(x) * 26'd5243;
        return p[24:17];
    endfunction

    // floor(23 * m / 9)
    function automatic logic [4:0] month_term(input logic [MONTH_W-1:0] m);
        logic [4:0] t;
        unique case (m)
            4'd1:    t = 5'd2;
            4'd2:    t = 5'd5;
            4'd3:    t = 5'd7;
            4'd4:    t = 5'd10;
            4'd5:    t = 5'd12;
            4'd6:    t = 5'd15;
            4'd7:    t = 5'd17;
            4'd8:    t = 5'd20;
            4'd9:    t = 5'd23;
            4'd10:   t = 5'd25;
            4'd11:   t = 5'd28;
            4'd12:   t = 5'd30;
            default: t = 5'd0;
        endcase
        return t;
    endfunction

    logic [14:0] ys;
    logic [14:0] dd;
    logic [14:0] yy;
    logic [7:0]  q100;
    logic [7:0]  q400;

    always_comb
    begin
        // shift by 400 years keeps every term positive
        ys = {1'b0, date.year} + 15'd400;
        if (date.month < MARCH)
        begin
            dd = ys + 15'd1;
            yy = ys - 15'd1;
        end
        else
        begin
            dd = ys - 15'd1;
            yy = ys;
        end
        q100 = quot_25(yy[14:2]);
        q400 = quot_25({2'b00, yy[14:4]});
        wday_sum = 15'(month_term(date.month)) + dd + 15'd4 + 15'(yy[14:2])
                   - 15'(q100) + 15'(q400);
        dim = month_length(date.month, is_leap(date.year));
    end

endmodule

`default_nettype wire
